// ----- rtl/core/swrbv_pkg.sv -----
package swrbv_pkg;

  // Built size of the stack and width of one entry
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  // Entry index and fill count widths (count must hold DEPTH itself)
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_NOMATCH  = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch the accepted item
    logic compare;  // register the match vector
    logic apply;    // update the stack and load the output register
  } swrbv_cmd_t;

endpackage

// ----- rtl/core/swrbv_in_if.sv -----
interface swrbv_in_if import swrbv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ----- rtl/core/swrbv_out_if.sv -----
interface swrbv_out_if import swrbv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [IDX_W-1:0]       match_index;
  logic                   top_valid;
  logic [VALUE_WIDTH-1:0] top_value;
  logic [CNT_W-1:0]       fill_level;

  modport source (output valid, output status, output match_index, output top_valid,
                  output top_value, output fill_level, input ready);
  modport sink   (input valid, input status, input match_index, input top_valid,
                  input top_value, input fill_level, output ready);
endinterface

// ----- rtl/core/stack_with_remove_by_value.sv -----
// Bounded LIFO of 32-bit words with remove-by-value.
// in_i  : item channel (valid/ready); opcode push or remove, value to push or to find.
// out_o : result channel (valid/ready); status, index of the removed entry, top entry
//         and its valid flag, and the fill level after the operation.
// cfg_we_i/cfg_wdata_i : capacity write, 0..16 in use; above 16 acts as 16.
//   Write only while idle; lowering it under the fill keeps all entries.
// Timing: an accepted item is latched, then compared against all occupied slots
//   in the compare state (registered match vector), then applied in the apply
//   state, when the result register loads and out_o.valid rises. in_i.ready returns
//   with the apply, so no new item is taken before the last one has been applied.
// Stall: the result register holds its item until taken. A new item can be
//   accepted while it waits, but its apply step holds off until the register
//   is free.
// Reset: asynchronous, active low. The stack empties, capacity returns to 16,
//   no result is pending. Entry storage is not cleared; no empty slot is read.
module stack_with_remove_by_value import swrbv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  swrbv_in_if.sink          in_i,
  swrbv_out_if.source       out_o,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i
);

  swrbv_cmd_t cmd;

  // sequencer: idle -> compare -> apply
  swrbv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // entry store, match search, shift-down and result register
  swrbv_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (in_i.opcode),
    .value_i       (in_i.value),
    .status_o      (out_o.status),
    .match_index_o (out_o.match_index),
    .top_valid_o   (out_o.top_valid),
    .top_value_o   (out_o.top_value),
    .fill_level_o  (out_o.fill_level)
  );

endmodule

// ----- rtl/core/swrbv_ctrl.sv -----
module swrbv_ctrl import swrbv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_ready_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output swrbv_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.compare = 1'b0;
    cmd_o.apply   = 1'b0;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_APPLY;
      end
      ST_APPLY: begin
        // hold here until the output register can take the result
        if (out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.apply) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CMP))
    else $error("accepted item did not move to compare");

  a_cmp_to_apply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |=> (state_q == ST_APPLY))
    else $error("compare not followed by apply");

  a_apply_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> (out_valid_q && state_q == ST_IDLE))
    else $error("apply did not present a result");

endmodule

// ----- rtl/core/swrbv_dp.sv -----
module swrbv_dp import swrbv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swrbv_cmd_t             cmd_i,
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i,
  input  logic                   opcode_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [IDX_W-1:0]       match_index_o,
  output logic                   top_valid_o,
  output logic [VALUE_WIDTH-1:0] top_value_o,
  output logic [CNT_W-1:0]       fill_level_o
);

  logic [VALUE_WIDTH-1:0] entries_q [DEPTH];
  logic [VALUE_WIDTH-1:0] entries_d [DEPTH];
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CAP_W-1:0]       cap_q;
  logic [CAP_W-1:0]       eff_cap;
  logic                   op_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [DEPTH-1:0]       hit_q, hit_d;
  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic [STATUS_W-1:0]    status_d;
  logic [IDX_W-1:0]       match_d;
  logic [CNT_W-1:0]       top_pos;
  logic [VALUE_WIDTH-1:0] top_d;

  assign eff_cap = (cap_q > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;

  // only occupied slots can match
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_d[i] = (entries_q[i] == val_q) && (CNT_W'(i) < cnt_q);
    end
  end

  // lowest matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign found = |hit_q;

  always_comb begin
    entries_d = entries_q;
    cnt_d     = cnt_q;
    status_d  = STATUS_OK;
    match_d   = '0;
    if (op_q == OP_PUSH) begin
      if (CAP_W'(cnt_q) < eff_cap) begin
        entries_d[cnt_q[IDX_W-1:0]] = val_q;
        cnt_d                       = cnt_q + CNT_W'(1);
      end else begin
        status_d = STATUS_OVERFLOW;
      end
    end else if (found) begin
      // close the gap: everything above the match drops by one
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IDX_W'(i) >= hit_idx) begin
          entries_d[i] = entries_q[i+1];
        end
      end
      cnt_d   = cnt_q - CNT_W'(1);
      match_d = hit_idx;
    end else begin
      status_d = STATUS_NOMATCH;
    end
  end

  assign top_pos = cnt_d - CNT_W'(1);
  assign top_d   = (cnt_d != '0) ? entries_d[top_pos[IDX_W-1:0]] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= CAP_RESET;
    end else begin
      if (cmd_i.apply) begin
        cnt_q <= cnt_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= value_i;
    end
    if (cmd_i.compare) begin
      hit_q <= hit_d;
    end
    if (cmd_i.apply) begin
      entries_q     <= entries_d;
      status_o      <= status_d;
      match_index_o <= match_d;
      top_valid_o   <= (cnt_d != '0);
      top_value_o   <= top_d;
      fill_level_o  <= cnt_d;
    end
  end

  a_cnt_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_cnt_only_on_apply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.apply |=> $stable(cnt_q))
    else $error("fill count moved without apply");

endmodule
